// ----- src/preset_fir_smoothing_filter_top_macros.svh -----
// Assertion macros shared by the smoothing filter modules.
// Expects clock and reset (synchronous, active high) in the using module.
`ifndef PRESET_FIR_SMOOTHING_FILTER_TOP_MACROS_SVH
`define PRESET_FIR_SMOOTHING_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PFSF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define PFSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/pfsf_pkg.sv -----
// Shared types, mode codes and coefficient tables of the smoothing filter.
// No dependencies.
package pfsf_pkg;

   // filter_mode codes
   localparam logic [1:0] MODE_GAUSS = 2'd0;
   localparam logic [1:0] MODE_SG5   = 2'd1;
   localparam logic [1:0] MODE_SG7   = 2'd2;
   localparam logic [1:0] MODE_SG9   = 2'd3;

   localparam int TAP_W  = 5;   // holds the longest preset (21 taps)
   localparam int COEF_W = 30;  // weight times reciprocal, signed

   // Weight times normalization reciprocal; first half of each symmetric preset.
   // Gaussian reciprocal 67960 (shift 31), SG reciprocals 1872, 3121, 284 (shift 16).
   localparam logic signed [COEF_W-1:0] GAUSS_COEF [0:10] = '{
      30'sd24057840,  30'sd35203280,  30'sd49406920,  30'sd66600800,
      30'sd86377160,  30'sd107784560, 30'sd128920120, 30'sd148288720,
      30'sd164123400, 30'sd174113520, 30'sd177715400
   };
   localparam logic signed [COEF_W-1:0] SG5_COEF [0:2] = '{
      -30'sd5616, 30'sd22464, 30'sd31824
   };
   localparam logic signed [COEF_W-1:0] SG7_COEF [0:3] = '{
      -30'sd6242, 30'sd9363, 30'sd18726, 30'sd21847
   };
   localparam logic signed [COEF_W-1:0] SG9_COEF [0:4] = '{
      -30'sd5964, 30'sd3976, 30'sd11076, 30'sd15336, 30'sd16756
   };

   // Controller to datapath
   typedef struct packed {
      logic start;  // transaction accepted: write sample, set up pass
      logic read;   // issue one window read and tap step
      logic norm;   // normalize and saturate the accumulator
      logic load;   // move the result into the output register
   } pfsf_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic apply;      // the incoming sample completes a full window
      logic last_tap;   // current read is the final tap
      logic pipe_busy;  // read or product still in flight
      logic out_free;   // output register can take a result
   } pfsf_status_type;

   function automatic logic [TAP_W-1:0] taps_of(input logic [1:0] mode);
      logic [TAP_W-1:0] t;
      case (mode)
         MODE_GAUSS: t = TAP_W'(21);
         MODE_SG5:   t = TAP_W'(5);
         MODE_SG7:   t = TAP_W'(7);
         MODE_SG9:   t = TAP_W'(9);
         default:    t = TAP_W'(21);
      endcase
      return t;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_of(input logic [1:0] mode,
                                                        input logic [TAP_W-1:0] k);
      logic [TAP_W-1:0] m;
      logic signed [COEF_W-1:0] c;
      m = '0;
      c = '0;
      case (mode)
         MODE_GAUSS: begin
            m = (k > TAP_W'(10)) ? TAP_W'(20) - k : k;
            c = GAUSS_COEF[m[3:0]];
         end
         MODE_SG5: begin
            m = (k > TAP_W'(2)) ? TAP_W'(4) - k : k;
            c = SG5_COEF[m[1:0]];
         end
         MODE_SG7: begin
            m = (k > TAP_W'(3)) ? TAP_W'(6) - k : k;
            c = SG7_COEF[m[1:0]];
         end
         MODE_SG9: begin
            m = (k > TAP_W'(4)) ? TAP_W'(8) - k : k;
            c = SG9_COEF[m[2:0]];
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ----- src/pfsf_ctrl.sv -----
// Sequencing state machine of the smoothing filter.
// Depends on pfsf_pkg and the shared assertion macros.
`include "preset_fir_smoothing_filter_top_macros.svh"

module pfsf_ctrl
   import pfsf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  pfsf_status_type status,
   output pfsf_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_NORM   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = status.apply ? ST_READ : ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PFSF_ASSERT_IMPL(a_load_free, cmd.load, status.out_free, "result load over pending output")
   `PFSF_ASSERT_IMPL(a_norm_drained, cmd.norm, !status.pipe_busy, "normalize with MAC in flight")
   `PFSF_ASSERT_NEXT(a_pass_direct, cmd.start && !status.apply, state_ff == ST_FINISH, "pass-through did not go to finish")

endmodule

// ----- src/pfsf_dp.sv -----
// Datapath of the smoothing filter: sample ring, serial MAC, normalizer, output register.
// Depends on pfsf_pkg and the shared assertion macros.
`include "preset_fir_smoothing_filter_top_macros.svh"

module pfsf_dp
   import pfsf_pkg::*;
#(
   parameter int MAX_TAPS     = 21,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pfsf_cmd_type                   cmd,
   output pfsf_status_type                status,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_wr_data,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered,
   output logic                           rsp_smoothed
);

   localparam int PTR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int FILL_W = $clog2(MAX_TAPS + 1);
   localparam int CMP_W  = (FILL_W > TAP_W) ? FILL_W : TAP_W;
   localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
   localparam int ACC_W  = SAMPLE_WIDTH + 33;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [ACC_W-1:0] RND_GAUSS = ACC_W'(1) << 30;
   localparam logic signed [ACC_W-1:0] RND_SG    = ACC_W'(1) << 15;

   logic [1:0]                     mode_ff;
   logic [PTR_W-1:0]               wptr_ff, wptr_in;
   logic [PTR_W-1:0]               rptr_ff, rptr_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic [TAP_W-1:0]               tap_ff;
   logic [TAP_W-1:0]               taps;
   logic signed [SAMPLE_WIDTH-1:0] ring [MAX_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] rdata_ff;
   logic signed [COEF_W-1:0]       coef_ff;
   logic                           rd_v_ff, mul_v_ff;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [ACC_W-1:0]        rounded, shifted;
   logic signed [SAMPLE_WIDTH-1:0] result_ff, result_in;
   logic                           smoothed_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_ff;
   logic                           rsp_smoothed_ff;
   logic                           tap_fits;

   assign taps = taps_of(mode_ff);

   // Ring pointers and saturating fill count
   assign wptr_in = (wptr_ff == PTR_W'(MAX_TAPS - 1)) ? '0 : wptr_ff + PTR_W'(1);
   assign rptr_in = (rptr_ff == '0) ? PTR_W'(MAX_TAPS - 1) : rptr_ff - PTR_W'(1);
   assign fill_in = (fill_ff == FILL_W'(MAX_TAPS)) ? fill_ff : fill_ff + FILL_W'(1);

   // Filter applies once the window covers the preset
   assign tap_fits = CMP_W'(taps) <= CMP_W'(MAX_TAPS);

   assign status.apply     = tap_fits && (CMP_W'(fill_in) >= CMP_W'(taps));
   assign status.last_tap  = (tap_ff == taps - TAP_W'(1));
   assign status.pipe_busy = rd_v_ff || mul_v_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GAUSS;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Window control: write pointer, fill count, read pointer, tap index
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         fill_ff <= '0;
         rptr_ff <= '0;
         tap_ff  <= '0;
      end else if (cmd.start) begin
         wptr_ff <= wptr_in;
         fill_ff <= fill_in;
         rptr_ff <= wptr_ff;
         tap_ff  <= '0;
      end else if (cmd.read) begin
         rptr_ff <= rptr_in;
         tap_ff  <= tap_ff + TAP_W'(1);
      end
   end

   // Sample ring: write newest, read newest-first during the pass
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ring[wptr_ff] <= req_sample;
      end
      if (cmd.read) begin
         rdata_ff <= ring[rptr_ff];
         coef_ff  <= coef_of(mode_ff, tap_ff);
      end
   end

   // Multiply-accumulate pipeline
   assign prod_in = rdata_ff * coef_ff;
   assign acc_in  = acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= cmd.read;
         mul_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         prod_ff <= prod_in;
      end
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (mul_v_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Round half up, drop the fraction, saturate
   assign rounded = acc_ff + ((mode_ff == MODE_GAUSS) ? RND_GAUSS : RND_SG);
   assign shifted = (mode_ff == MODE_GAUSS) ? (rounded >>> 31) : (rounded >>> 16);

   always_comb begin
      if (shifted > SAT_HI) begin
         result_in = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (shifted < SAT_LO) begin
         result_in = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         result_in = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   // Hold pass-through sample until normalize replaces it
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         result_ff   <= req_sample;
         smoothed_ff <= status.apply;
      end else if (cmd.norm) begin
         result_ff <= result_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_filtered_ff <= result_ff;
         rsp_smoothed_ff <= smoothed_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_smoothed = rsp_smoothed_ff;

   `PFSF_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= FILL_W'(MAX_TAPS), "fill count past window depth")
   `PFSF_ASSERT_NEXT(a_load_shows, cmd.load, rsp_valid_ff, "loaded result not presented")
   `PFSF_ASSERT_IMPL(a_read_fits, cmd.read, tap_ff < taps, "tap index beyond preset length")

endmodule

// ----- src/preset_fir_smoothing_filter_top.sv -----
// A filtered transaction steps through the read, drain, normalize and finish states,
// one MAC per tap through the single ring read port; pass-through goes straight to finish.
// A new transaction is accepted only in the idle state, once the previous result is loaded.
// Reset (synchronous, high): mode Gaussian, window empty, no result pending.
// Top level: joins the sequencing controller and the filter datapath.
module preset_fir_smoothing_filter_top
   import pfsf_pkg::*;
#(
   parameter int MAX_TAPS     = 21,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered,
   output logic                           rsp_smoothed
);

   pfsf_cmd_type    cmd;
   pfsf_status_type status;

   pfsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfsf_dp #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .rsp_smoothed (rsp_smoothed)
   );

endmodule

// ----- bench/preset_fir_smoothing_filter_checker.sv -----
// Scoreboard for the preset smoothing filter: watches both channels and the CSR port,
// predicts each filtered sample and compares it with the accepted result.
// Depends on pfsf_pkg for the filter mode codes.
module preset_fir_smoothing_filter_checker
   import pfsf_pkg::*;
#(
   parameter int MAX_TAPS     = 21,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_wr_data,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] rsp_filtered,
   input  logic                           rsp_smoothed,
   output int                             mismatch_count,
   output int                             results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] filtered;
      logic                           smoothed;
   } smooth_out_type;

   // Predictor state: newest sample at index 0
   logic signed [SAMPLE_WIDTH-1:0] history [MAX_TAPS];
   int                             held;
   logic [1:0]                     active_mode;
   smooth_out_type                 due_results [$];
   int                             errors = 0;

   assign mismatch_count = errors;
   initial results_due = 0;

   function automatic int preset_taps(input logic [1:0] mode);
      case (mode)
         MODE_SG5: return 5;
         MODE_SG7: return 7;
         MODE_SG9: return 9;
         default:  return 21;
      endcase
   endfunction

   // Normalization reciprocal of the weight sum and its binary point
   function automatic longint preset_recip(input logic [1:0] mode);
      case (mode)
         MODE_SG5: return 1872;
         MODE_SG7: return 3121;
         MODE_SG9: return 284;
         default:  return 67960;
      endcase
   endfunction

   function automatic int preset_shift(input logic [1:0] mode);
      return (mode == MODE_GAUSS) ? 31 : 16;
   endfunction

   // Symmetric presets: fold the tap index onto the first half
   function automatic longint tap_weight(input logic [1:0] mode, input int tap);
      int k;
      k = (tap > preset_taps(mode) / 2) ? preset_taps(mode) - 1 - tap : tap;
      case (mode)
         MODE_SG5:
            case (k)
               0:       return -3;
               1:       return 12;
               default: return 17;
            endcase
         MODE_SG7:
            case (k)
               0:       return -2;
               1:       return 3;
               2:       return 6;
               default: return 7;
            endcase
         MODE_SG9:
            case (k)
               0:       return -21;
               1:       return 14;
               2:       return 39;
               3:       return 54;
               default: return 59;
            endcase
         default:
            case (k)
               0:       return 354;
               1:       return 518;
               2:       return 727;
               3:       return 980;
               4:       return 1271;
               5:       return 1586;
               6:       return 1897;
               7:       return 2182;
               8:       return 2415;
               9:       return 2562;
               default: return 2615;
            endcase
      endcase
   endfunction

   // Shift one sample into the window and work out the filter output it causes
   function automatic smooth_out_type smooth_next(input logic signed [SAMPLE_WIDTH-1:0] sample);
      smooth_out_type r;
      int             taps;
      int             shift;
      longint         acc;
      longint         scaled;
      longint         top;
      for (int i = MAX_TAPS - 1; i > 0; i--)
         history[i] = history[i-1];
      history[0] = sample;
      if (held < MAX_TAPS)
         held++;
      taps = preset_taps(active_mode);
      if (held >= taps) begin
         shift = preset_shift(active_mode);
         acc = 0;
         for (int i = 0; i < taps; i++)
            acc += tap_weight(active_mode, i) * longint'(history[taps-1-i]);
         scaled = (acc * preset_recip(active_mode) + (longint'(1) << (shift - 1))) >>> shift;
         top = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
         if (scaled > top)
            scaled = top;
         else if (scaled < -top - 1)
            scaled = -top - 1;
         r.filtered = SAMPLE_WIDTH'(scaled);
         r.smoothed = 1'b1;
      end else begin
         r.filtered = sample;
         r.smoothed = 1'b0;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      errors++;
      if (errors <= 10)
         $display("%0t ns: %s", $time, msg);
   endtask

   // Track the CSR, check outgoing transactions, then queue the incoming one
   always @(posedge clock) begin : track
      smooth_out_type got;
      smooth_out_type want;
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++)
            history[i] = '0;
         held = 0;
         active_mode = MODE_GAUSS;
         due_results.delete();
      end else begin
         if (csr_wr_en)
            active_mode = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            got.filtered = rsp_filtered;
            got.smoothed = rsp_smoothed;
            if (due_results.size() == 0) begin
               flag_mismatch($sformatf("unexpected result filtered=%0d smoothed=%0b",
                                       got.filtered, got.smoothed));
            end else begin
               want = due_results.pop_front();
               if (got.filtered !== want.filtered || got.smoothed !== want.smoothed)
                  flag_mismatch($sformatf("filtered exp %0d got %0d, smoothed exp %0b got %0b",
                                          want.filtered, got.filtered,
                                          want.smoothed, got.smoothed));
            end
         end
         if (req_valid && req_ready)
            due_results.push_back(smooth_next(req_sample));
      end
      results_due <= due_results.size();
   end

endmodule

// ----- bench/preset_fir_smoothing_filter_top_tb.sv -----
// Testbench top for the preset smoothing filter: clock, reset, stimulus and verdict.
// Depends on pfsf_pkg, preset_fir_smoothing_filter_top and the checker module.
module preset_fir_smoothing_filter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pfsf_pkg::*;

   localparam int MAX_TAPS     = 21;
   localparam int SAMPLE_WIDTH = 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SEGMENTS     = 16;
   localparam int SEGMENT_LEN  = 100;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           csr_wr_en   = 1'b0;
   logic [1:0]                     csr_wr_data = MODE_GAUSS;
   logic                           req_valid   = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_sample  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready   = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered;
   logic                           rsp_smoothed;

   int mismatches;
   int results_due;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   logic hold_start  = 1'b0;
   int cycle_count   = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   preset_fir_smoothing_filter_top #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .rsp_smoothed (rsp_smoothed)
   );

   preset_fir_smoothing_filter_checker #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered),
      .rsp_smoothed   (rsp_smoothed),
      .mismatch_count (mismatches),
      .results_due    (results_due)
   );

   // Receiver: random stalls, or a long hold-off once requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_start) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: end the run if it never drains
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Offer one transaction after optional idle cycles; return at its acceptance edge
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Drop valid and wait until every predicted result has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (results_due != 0);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly full-range samples, some rail values, some near zero
   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6)
         return SAMPLE_WIDTH'($urandom);
      else if (pick < 8)
         return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else
         return SAMPLE_WIDTH'(int'($urandom_range(64)) - 32);
   endfunction

   initial begin : stimulus
      int mode_pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short preset from empty window: pass-through, then both saturation rails
      write_mode(MODE_SG5);
      send_sample(SAMPLE_WIDTH'(32767));
      send_sample(SAMPLE_WIDTH'(-32768));
      send_sample(SAMPLE_WIDTH'(-32768));
      send_sample(SAMPLE_WIDTH'(-32768));
      send_sample(SAMPLE_WIDTH'(32767));
      send_sample(SAMPLE_WIDTH'(32767));
      send_sample(SAMPLE_WIDTH'(32767));
      send_sample(SAMPLE_WIDTH'(-32768));

      // Longest preset: window still short, pass through until it is full
      drain_results();
      write_mode(MODE_GAUSS);
      send_sample(SAMPLE_WIDTH'(0));
      send_sample(SAMPLE_WIDTH'(-1));
      send_sample(SAMPLE_WIDTH'(1));
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      for (int i = 0; i < 8; i++)
         send_sample(random_sample());

      // Random segments: rotate preset and idle pattern, full window kept across modes
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_results();
         mode_pick = (seg + seg / 4) % 4;
         case (mode_pick)
            0:       write_mode(MODE_GAUSS);
            1:       write_mode(MODE_SG5);
            2:       write_mode(MODE_SG7);
            default: write_mode(MODE_SG9);
         endcase
         case (seg % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct    <= 0;
            end
            1: begin
               send_idle_pct = 77;
               stall_pct    <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct    <= 77;
            end
            default: begin
               send_idle_pct = 12;
               stall_pct    <= 12;
            end
         endcase
         // Back-pressure: hold the receiver while the sender keeps offering
         if (seg == 4) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         for (int n = 0; n < SEGMENT_LEN; n++)
            send_sample(random_sample());
      end

      drain_results();
      repeat (64) @(posedge clock);
      if (mismatches == 0 && results_due == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
